// ===== src/tmr_pkg.sv =====
// Shared types and constants for the tile map pixel renderer.
// No dependencies; the front, queue, back and top files in src use it by scoped names.
package tmr_pkg;

  localparam int unsigned TILE_COUNT = 2048;
  localparam int unsigned STORE_AW   = 16;            // pattern store address bits
  localparam int unsigned TILE_W     = STORE_AW - 5;  // 32 bytes per tile
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = $clog2(QDEPTH);

  localparam logic [TILE_W-1:0] SPRITE_BASE = TILE_W'(11'h380);

  typedef enum logic {
    CMD_WRITE,
    CMD_DRAW
  } cmd_kind_t;

  // One queued command: a pattern byte write or a draw that will emit pixels.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
    logic [TILE_W-1:0]   tile;
    logic                flip_x;
    logic                flip_y;
    logic [1:0]          pal;
    logic [4:0]          cx;
    logic [4:0]          cy;
    logic                fg;
  } cmd_t;

endpackage

// ===== src/tmr_front.sv =====
// Front end: takes input words, holds sprite_mode, rebases and filters draws.
// Depends on tmr_pkg.
module tmr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [tmr_pkg::STORE_AW-1:0] pattern_addr,
  input  logic [7:0]                   pattern_byte,
  input  logic [15:0]                  tile_entry,
  input  logic [4:0]                   cell_x,
  input  logic [4:0]                   cell_y,
  input  logic                         layer,
  input  logic                         q_full,
  output logic                         push,
  output tmr_pkg::cmd_t                push_cmd
);

  logic                        sprite_mode;
  logic [tmr_pkg::TILE_W-1:0]  tile_raw;
  logic [tmr_pkg::TILE_W-1:0]  tile;
  logic                        rebase;
  logic                        skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_mode <= 1'b0;
    end else if (cfg_write) begin
      sprite_mode <= cfg_data;
    end
  end

  always_comb begin
    tile_raw = tile_entry[tmr_pkg::TILE_W-1:0];
    rebase   = layer && sprite_mode;
    tile     = rebase ? (tile_raw - tmr_pkg::SPRITE_BASE) : tile_raw;
    // draws that give no pixels never reach the queue
    skip = (!layer && sprite_mode) || (tile_raw == '0) || (rebase && (tile == '0))
           || ({1'b0, tile} >= (tmr_pkg::TILE_W + 1)'(tmr_pkg::TILE_COUNT));

    push_cmd.kind   = action ? tmr_pkg::CMD_DRAW : tmr_pkg::CMD_WRITE;
    push_cmd.addr   = pattern_addr;
    push_cmd.data   = pattern_byte;
    push_cmd.tile   = tile;
    push_cmd.flip_x = tile_entry[11];
    push_cmd.flip_y = tile_entry[12];
    push_cmd.pal    = tile_entry[14:13];
    push_cmd.cx     = cell_x;
    push_cmd.cy     = cell_y;
    push_cmd.fg     = layer;

    in_stall = q_full;
    push     = in_valid && !q_full && !(action && skip);
  end

endmodule

// ===== src/tmr_queue.sv =====
// Short command queue between front and back end.
// Depends on tmr_pkg.
module tmr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tmr_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  tmr_pkg::cmd_t              entries [tmr_pkg::QDEPTH];
  logic [tmr_pkg::QAW-1:0]    wr_ptr;
  logic [tmr_pkg::QAW-1:0]    rd_ptr;
  logic [tmr_pkg::QAW:0]      count;
  logic [tmr_pkg::QAW:0]      count_next;

  always_comb begin
    empty      = (count == '0);
    full       = (count == (tmr_pkg::QAW + 1)'(tmr_pkg::QDEPTH));
    head       = entries[rd_ptr];
    count_next = count + (tmr_pkg::QAW + 1)'(push) - (tmr_pkg::QAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

// ===== src/tmr_back.sv =====
// Back end: pattern store, 64-pixel draw sequencer, read stage, output register.
// Depends on tmr_pkg.
module tmr_back (
  input  logic          clk,
  input  logic          rst,
  input  tmr_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    pixel_x,
  output logic [7:0]    pixel_y,
  output logic [5:0]    color,
  output logic          write_enable,
  output logic          last
);

  logic [7:0]                   mem [2**tmr_pkg::STORE_AW];
  tmr_pkg::cmd_t                cur;
  logic                         busy;
  logic [5:0]                   cnt;
  logic [2:0]                   r, c, sr, sc;
  logic [tmr_pkg::STORE_AW-1:0] rd_addr;
  logic                         issue, out_ld, last_issue, busy_next;

  // read stage
  logic       s1_valid;
  logic [7:0] rd_data;
  logic [7:0] s1_x, s1_y;
  logic [1:0] s1_pal;
  logic       s1_fg, s1_lo, s1_last;
  logic [3:0] nib;

  always_comb begin
    r          = cnt[5:3];
    c          = cnt[2:0];
    sr         = cur.flip_y ? ~r : r;
    sc         = cur.flip_x ? ~c : c;
    rd_addr    = {cur.tile, sr, sc[2:1]};
    out_ld     = !out_valid || !out_stall;
    issue      = busy && (!s1_valid || out_ld);
    last_issue = issue && (cnt == 6'd63);
    pop        = !empty && (!busy || last_issue);
    busy_next  = busy;
    if (pop && (head.kind == tmr_pkg::CMD_DRAW)) begin
      busy_next = 1'b1;
    end else if (last_issue) begin
      busy_next = 1'b0;
    end
    nib = s1_lo ? rd_data[3:0] : rd_data[7:4];
  end

  // pattern store: byte writes from the queue, one read per issued pixel
  always_ff @(posedge clk) begin
    if (pop && (head.kind == tmr_pkg::CMD_WRITE)) begin
      mem[head.addr] <= head.data;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind == tmr_pkg::CMD_DRAW)) begin
      cur <= head;
    end
    if (issue) begin
      s1_x    <= {cur.cx, c};
      s1_y    <= {cur.cy, r};
      s1_pal  <= cur.pal;
      s1_fg   <= cur.fg;
      s1_lo   <= sc[0];
      s1_last <= (cnt == 6'd63);
    end
    if (out_ld && s1_valid) begin
      pixel_x      <= s1_x;
      pixel_y      <= s1_y;
      color        <= {s1_pal, nib};
      write_enable <= !s1_fg || (nib != 4'd0);
      last         <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (pop && (head.kind == tmr_pkg::CMD_DRAW)) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 6'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_ld) begin
        s1_valid <= 1'b0;
      end
      if (out_ld) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

// ===== src/tile_map_pixel_renderer_core.sv =====
// Top level of the tile map pixel renderer.
// Depends on tmr_pkg, tmr_front, tmr_queue and tmr_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per item. action 0 stores
//    pattern_byte at pattern_addr; action 1 draws the 8x8 tile named by
//    tile_entry at cell (cell_x, cell_y) on the given layer.
//  - Output channel (out_valid / out_stall): one word per pixel, 64 per drawn
//    tile in raster order, last high on the 64th.
//  - cfg_write / cfg_data set sprite_mode; write it only while idle.
//  - Draws that produce nothing (index zero, background in sprite mode,
//    rebased index zero) are accepted from the input but never queued.
//  - A draw goes through the queue and the draw sequencer, its first pixel
//    through the read stage and output register. Pixels leave one a cycle
//    while out_stall is low, set by the single pattern store read port.
//  - A four-word command queue sits between front and back end, so input is
//    taken while a draw is still emitting; in_stall rises only when it fills.
//  - When the receiver stalls, the output word holds and the draw sequencer
//    pauses with one pixel waiting in the read stage; nothing is dropped.
//  - Reset (rst, synchronous) clears sprite_mode, the queue and the
//    sequencer. The pattern store is not cleared: bytes are undefined until
//    written.
module tile_map_pixel_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] pattern_addr,
  input  logic [7:0]  pattern_byte,
  input  logic [15:0] tile_entry,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic        layer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_x,
  output logic [7:0]  pixel_y,
  output logic [5:0]  color,
  output logic        write_enable,
  output logic        last
);

  // front to queue
  logic          push;
  tmr_pkg::cmd_t push_cmd;
  logic          q_full;

  // queue to back
  tmr_pkg::cmd_t head;
  logic          q_empty;
  logic          pop;

  tmr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .pattern_addr (pattern_addr),
    .pattern_byte (pattern_byte),
    .tile_entry   (tile_entry),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .layer        (layer),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // commands keep their order, so a draw always sees earlier pattern writes
  tmr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tmr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color        (color),
    .write_enable (write_enable),
    .last         (last)
  );

endmodule

// ===== src/tmr_checker.sv =====
// Port-level checks for the tile map pixel renderer, bound to the top level.
// Depends on tile_map_pixel_renderer_core only through its ports.
module tmr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_x,
  input logic [7:0] pixel_y,
  input logic [5:0] color,
  input logic       write_enable,
  input logic       last
);

  // a stalled pixel word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(color) && $stable(write_enable) && $stable(last))
    else $error("stalled pixel word changed");

  // nothing comes out the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // last marks exactly the bottom-right pixel of a tile
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == ((pixel_x[2:0] == 3'd7) && (pixel_y[2:0] == 3'd7))))
    else $error("last flag on wrong pixel");

  // within a tile pixels follow without gaps, column by column
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid
      && (pixel_x[2:0] == $past(pixel_x[2:0]) + 3'd1))
    else $error("gap or wrong column inside a tile");

endmodule

bind tile_map_pixel_renderer_core tmr_checker u_tmr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_x      (pixel_x),
  .pixel_y      (pixel_y),
  .color        (color),
  .write_enable (write_enable),
  .last         (last)
);

// ===== bench/pixel_check_pkg.sv =====
`timescale 1ns / 100ps
// Pixel predictor and scoreboard for the tile map renderer bench.
// Depends on tmr_pkg for the command kinds, tile count and sprite base.
package pixel_check_pkg;
  import tmr_pkg::*;

  localparam logic LAYER_BG    = 1'b0;
  localparam logic LAYER_FG    = 1'b1;
  localparam logic MODE_TILE   = 1'b0;
  localparam logic MODE_SPRITE = 1'b1;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [5:0] color;
    logic       we;
    logic       last;
  } pixel_t;

  class pixel_scoreboard;
    bit [7:0] pattern_mem [0:65535];
    logic     sprite_mode;
    pixel_t   pixels_due [$];
    int       errors;

    function new();
      sprite_mode = MODE_TILE;
      errors = 0;
    endfunction

    function void set_mode(logic m);
      sprite_mode = m;
    endfunction

    // 64 pixels of one tile in raster order, flips applied on the source side
    function void paint_tile(logic [10:0] tile, logic flip_y, logic flip_x, logic [1:0] pal,
                             logic [4:0] cx, logic [4:0] cy, logic fg);
      logic [2:0] sr;
      logic [2:0] sc;
      logic [7:0] b;
      logic [3:0] nib;
      pixel_t     p;
      for (int r = 0; r < 8; r++) begin
        sr = flip_y ? 3'(7 - r) : 3'(r);
        for (int c = 0; c < 8; c++) begin
          sc = flip_x ? 3'(7 - c) : 3'(c);
          b = pattern_mem[{tile, sr, sc[2:1]}];
          nib = sc[0] ? b[3:0] : b[7:4];
          p.x = {cx, 3'(c)};
          p.y = {cy, 3'(r)};
          p.color = {pal, nib};
          p.we = (fg == LAYER_FG) ? (nib != 4'd0) : 1'b1;
          p.last = (r == 7 && c == 7);
          pixels_due.push_back(p);
        end
      end
    endfunction

    function void take_word(cmd_kind_t kind, logic [15:0] addr, logic [7:0] data,
                            logic [15:0] entry, logic [4:0] cx, logic [4:0] cy, logic fg);
      logic [10:0] tile;
      if (kind == CMD_WRITE) begin
        pattern_mem[addr] = data;
        return;
      end
      tile = entry[10:0];
      if (fg == LAYER_BG && sprite_mode == MODE_SPRITE) return;
      if (tile == 11'd0) return;
      if (fg == LAYER_FG && sprite_mode == MODE_SPRITE) begin
        tile = tile - SPRITE_BASE;
        if (tile == 11'd0) return;
      end
      if (int'(tile) >= TILE_COUNT) return;
      paint_tile(tile, entry[12], entry[11], entry[14:13], cx, cy, fg);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: pixel (%0d,%0d) colour %0d with no draw outstanding",
                 $time, got.x, got.y, got.color);
        return;
      end
      want = pixels_due.pop_front();
      if (got.x != want.x || got.y != want.y || got.color != want.color ||
          got.we != want.we || got.last != want.last) begin
        errors++;
        $display("%0t: expected x=%0d y=%0d colour=%0d we=%0b last=%0b,",
                 $time, want.x, want.y, want.color, want.we, want.last,
                 " got x=%0d y=%0d colour=%0d we=%0b last=%0b",
                 got.x, got.y, got.color, got.we, got.last);
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the tile map renderer bench: clock, reset, word drivers and pixel monitor.
// Depends on tmr_pkg, pixel_check_pkg and tile_map_pixel_renderer_core.
module tb_top;
  import tmr_pkg::*;
  import pixel_check_pkg::*;

  localparam int          RANDOM_WORDS = 400;
  localparam int          PHASES       = 4;
  // margin after the last predicted pixel; allows for queued writes too
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [15:0] pattern_addr;
  logic [7:0]  pattern_byte;
  logic [15:0] tile_entry;
  logic [4:0]  cell_x;
  logic [4:0]  cell_y;
  logic        layer;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [5:0]  color;
  logic        write_enable;
  logic        last;

  pixel_scoreboard sb;

  // Stimulus-side record of which pattern bytes hold defined data; a draw that
  // emits pixels only ever reads a tile whose 32 bytes have all been written.
  bit          written [0:65535];
  bit          tile_listed [0:2047];
  int          ready_tiles [$];
  logic        cur_mode;
  bit          tx_quiet;   // sender: no gaps
  bit          rx_quiet;   // receiver: no stalls
  int          words_sent;
  int unsigned cycles = 0;

  always #2 clk = ~clk;

  tile_map_pixel_renderer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .pattern_addr (pattern_addr),
    .pattern_byte (pattern_byte),
    .tile_entry   (tile_entry),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .layer        (layer),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color        (color),
    .write_enable (write_enable),
    .last         (last)
  );

  // Run guard: a hung handshake or pixels that never arrive end here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Pixel monitor: sampled at the edge, so values are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel('{pixel_x, pixel_y, color, write_enable, last});
  end

  // Receiver: per word, maybe stall first, then take it.
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Records a written byte and lists its tile once all 32 bytes are defined.
  function automatic void mark_written(logic [15:0] addr);
    int  t;
    bit  full;
    written[addr] = 1'b1;
    t = int'(addr[15:5]);
    if (tile_listed[t]) return;
    full = 1'b1;
    for (int k = 0; k < 32; k++)
      if (!written[t * 32 + k]) full = 1'b0;
    if (full) begin
      tile_listed[t] = 1'b1;
      ready_tiles.push_back(t);
    end
  endfunction

  // Zero nibbles are made common so that transparency shows up often.
  function automatic logic [7:0] random_pixel_pair();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    lo = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    return {hi, lo};
  endfunction

  // One input word: random gap, present, hold until taken, then predict.
  task automatic send_word(cmd_kind_t kind, logic [15:0] addr, logic [7:0] data,
                           logic [15:0] entry, logic [4:0] cx, logic [4:0] cy, logic fg);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= kind;
    pattern_addr <= addr;
    pattern_byte <= data;
    tile_entry   <= entry;
    cell_x       <= cx;
    cell_y       <= cy;
    layer        <= fg;
    do @(posedge clk); while (in_stall);
    sb.take_word(kind, addr, data, entry, cx, cy, fg);
    if (kind == CMD_WRITE) mark_written(addr);
    words_sent++;
  endtask

  // Draw fields are don't-care on a write, and the reverse; both randomised.
  task automatic write_byte(logic [15:0] addr, logic [7:0] data);
    send_word(CMD_WRITE, addr, data, 16'($urandom), 5'($urandom), 5'($urandom),
              1'($urandom));
  endtask

  task automatic draw_tile(logic [15:0] entry, logic [4:0] cx, logic [4:0] cy, logic fg);
    send_word(CMD_DRAW, 16'($urandom), 8'($urandom), entry, cx, cy, fg);
  endtask

  task automatic load_tile(int t);
    for (int k = 0; k < 32; k++)
      write_byte(16'(t * 32 + k), random_pixel_pair());
  endtask

  // Picks a draw that either reads a fully written tile or yields nothing.
  task automatic random_draw();
    int          pick;
    int          t;
    logic        fg;
    logic [10:0] idx;
    logic [15:0] entry;
    pick  = $urandom_range(0, 9);
    fg    = 1'($urandom);
    entry = 16'($urandom);
    if (pick == 0 || ready_tiles.size() == 0) begin
      idx = 11'd0;
    end else if (pick == 1 && cur_mode == MODE_SPRITE) begin
      idx = 11'($urandom);
      fg  = LAYER_BG;
    end else if (pick == 2 && cur_mode == MODE_SPRITE) begin
      idx = SPRITE_BASE;
      fg  = LAYER_FG;
    end else begin
      t   = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
      idx = (cur_mode == MODE_SPRITE && fg == LAYER_FG) ? 11'(t) + SPRITE_BASE : 11'(t);
    end
    entry[10:0] = idx;
    draw_tile(entry, 5'($urandom), 5'($urandom), fg);
  endtask

  // Sender holds off until every predicted pixel is out, then a margin for
  // draws that emit nothing and writes still in the command queue.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_mode(m);
    cur_mode = m;
  endtask

  initial begin
    int  budget;
    int  rv;
    int  t;
    bit  paused;
    sb = new();
    cur_mode   = MODE_TILE;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    words_sent = 0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= 1'b0;
    in_valid     <= 1'b0;
    action       <= CMD_WRITE;
    pattern_addr <= '0;
    pattern_byte <= '0;
    tile_entry   <= '0;
    cell_x       <= '0;
    cell_y       <= '0;
    layer        <= LAYER_BG;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_mode(MODE_TILE);

    // Directed: tile 1 holds every nibble value, zeros included; tile 2047
    // reaches the top of the pattern store. Address zero written on its own.
    for (int k = 0; k < 32; k++)
      write_byte(16'(32 + k), {4'(k), ~4'(k)});
    load_tile(TILE_COUNT - 1);
    write_byte(16'h0000, 8'hAA);

    draw_tile(16'h0001, 5'd0, 5'd0, LAYER_BG);            // plain, top-left corner
    draw_tile(16'h6801, 5'd31, 5'd27, LAYER_FG);          // flip x, palette 3, bottom-right
    draw_tile(16'h3001, 5'd31, 5'd31, LAYER_BG);          // flip y, rows below the screen
    draw_tile(16'hFFFF, 5'd0, 5'd28, LAYER_FG);           // index 2047, both flips, top bit set
    draw_tile(16'h7800, 5'd5, 5'd5, LAYER_BG);            // index zero: nothing
    draw_tile(16'h0001, 5'd16, 5'd14, LAYER_FG);          // foreground transparency
    drain();
    set_mode(MODE_SPRITE);
    draw_tile(16'h0001, 5'd3, 5'd3, LAYER_BG);            // background skipped
    draw_tile(16'h0381, 5'd4, 5'd4, LAYER_FG);            // rebased to tile 1
    draw_tile(16'h037F, 5'd7, 5'd9, LAYER_FG);            // wraps round to tile 2047
    draw_tile(16'h0380, 5'd8, 5'd8, LAYER_FG);            // rebases to zero: nothing
    draw_tile(16'h0000, 5'd8, 5'd8, LAYER_FG);            // index zero in sprite mode
    draw_tile(16'h5B81, 5'd30, 5'd2, LAYER_FG);           // rebased, both flips, palette 2

    // Random phases: sprite mode alternates, idling differs per phase.
    paused = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_mode(ph[0] ? MODE_SPRITE : MODE_TILE);
      tx_quiet = (ph >= 2);
      rx_quiet = ph[0];
      budget = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < budget) begin
        // one full hold-off in the middle of the first phase
        if (ph == 0 && !paused && words_sent >= budget - 60) begin
          drain();
          paused = 1'b1;
        end
        rv = $urandom_range(0, 99);
        if (rv < 5) begin
          load_tile($urandom_range(1, TILE_COUNT - 1));
        end else if (rv < 15) begin
          write_byte(16'($urandom), random_pixel_pair());
        end else if (rv < 22) begin
          t = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
          write_byte({11'(t), 5'($urandom)}, random_pixel_pair());
        end else begin
          random_draw();
        end
      end
    end

    drain();
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
